// File: src/bll_pkg.sv
// Shared types, constants and helper functions of the binary lifting
// lowest-common-ancestor engine. No dependencies.
package bll_pkg;

  localparam int NODE_W      = 10;
  localparam int DEPTH_W     = 10;
  localparam int LIFT_LEVELS = 10;
  localparam int LVL_W       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int ANC_AW      = NODE_W + LVL_W;

  localparam logic [LVL_W-1:0] LVL_FIRST = LVL_W'(1);
  localparam logic [LVL_W-1:0] LVL_LAST  = LVL_W'(LIFT_LEVELS - 1);

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } bll_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_DEP,
    ST_ADD_LIFT,
    ST_Q_DEP,
    ST_Q_UP_ANC,
    ST_Q_UP_DEP,
    ST_Q_CHK,
    ST_Q_LIFT,
    ST_Q_FIN,
    ST_DONE
  } bll_state_e;

  typedef struct packed {
    logic              we;
    logic [ANC_AW-1:0] waddr;
    logic [NODE_W-1:0] wdata;
    logic [ANC_AW-1:0] raddr0;
    logic [ANC_AW-1:0] raddr1;
  } bll_anc_req_t;

  typedef struct packed {
    logic               we;
    logic [NODE_W-1:0]  waddr;
    logic [DEPTH_W-1:0] wdata;
    logic [NODE_W-1:0]  raddr0;
    logic [NODE_W-1:0]  raddr1;
  } bll_dep_req_t;

  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] node;
  } bll_res_t;

  // Entry (node, level) of the ancestor memory.
  function automatic logic [ANC_AW-1:0] anc_addr(logic [NODE_W-1:0] node,
                                                 logic [LVL_W-1:0] lvl);
    return {node, lvl};
  endfunction

  // Parent depth plus one, held at the largest depth.
  function automatic logic [DEPTH_W-1:0] depth_inc(logic [DEPTH_W-1:0] d);
    return (d == '1) ? d : d + 1'b1;
  endfunction

endpackage

// File: src/binary_lifting_lca_top.sv
// Binary lifting lowest-common-ancestor engine, one item at a time.
// Add: each ancestor level is filled from a read of the ancestor memory at the
// level below. Query: the deeper node is walked up to the depth of the other,
// then both are lifted; equal nodes go straight to the result. Each depth-walk
// level costs two memory reads.
// Reset clears control state only; the memories get no clearing pass.
module binary_lifting_lca_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       opcode_i,
  input  logic [bll_pkg::NODE_W-1:0] node_a_i,
  input  logic [bll_pkg::NODE_W-1:0] node_b_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bll_pkg::NODE_W-1:0] ancestor_node_o
);

  bll_pkg::bll_anc_req_t        anc_req;
  bll_pkg::bll_dep_req_t        dep_req;
  bll_pkg::bll_res_t            res;
  logic [bll_pkg::NODE_W-1:0]   anc_rdata0, anc_rdata1;
  logic [bll_pkg::DEPTH_W-1:0]  dep_rdata0, dep_rdata1;
  logic                         res_ready;
  logic                         out_valid_q, out_valid_d;
  logic [bll_pkg::NODE_W-1:0]   out_node_q, out_node_d;

  bll_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .node_a_i     (node_a_i),
    .node_b_i     (node_b_i),
    .anc_req_o    (anc_req),
    .anc_rdata0_i (anc_rdata0),
    .anc_rdata1_i (anc_rdata1),
    .dep_req_o    (dep_req),
    .dep_rdata0_i (dep_rdata0),
    .dep_rdata1_i (dep_rdata1),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  bll_ram #(
    .ADDR_W (bll_pkg::ANC_AW),
    .DATA_W (bll_pkg::NODE_W)
  ) u_anc_ram (
    .clk_i    (clk_i),
    .we_i     (anc_req.we),
    .waddr_i  (anc_req.waddr),
    .wdata_i  (anc_req.wdata),
    .raddr0_i (anc_req.raddr0),
    .raddr1_i (anc_req.raddr1),
    .rdata0_o (anc_rdata0),
    .rdata1_o (anc_rdata1)
  );

  bll_ram #(
    .ADDR_W (bll_pkg::NODE_W),
    .DATA_W (bll_pkg::DEPTH_W)
  ) u_dep_ram (
    .clk_i    (clk_i),
    .we_i     (dep_req.we),
    .waddr_i  (dep_req.waddr),
    .wdata_i  (dep_req.wdata),
    .raddr0_i (dep_req.raddr0),
    .raddr1_i (dep_req.raddr1),
    .rdata0_o (dep_rdata0),
    .rdata1_o (dep_rdata1)
  );

  // The output register frees the sequencer while a result waits.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_node_d  = out_node_q;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
      out_node_d  = res.node;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_node_q <= out_node_d;
  end

  assign out_valid_o     = out_valid_q;
  assign ancestor_node_o = out_node_q;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && !res_ready |=> res.valid && $stable(res.node))
    else $error("pending result changed before transfer to the output register");

  a_no_write_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res.valid && (anc_req.we || dep_req.we)))
    else $error("memory written while a query result is pending");

  a_same_node_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (opcode_i == bll_pkg::OP_QUERY) &&
    (node_a_i == node_b_i) |=> res.valid && (res.node == $past(node_a_i)))
    else $error("query of one node did not return that node");

  a_stall_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> in_stall_o)
    else $error("input transfer possible while a result is pending");

endmodule

// File: src/bll_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// A read of the entry written in the same cycle returns the new data.
// No dependencies.
module bll_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr0_i,
  input  logic [ADDR_W-1:0] raddr1_i,
  output logic [DATA_W-1:0] rdata0_o,
  output logic [DATA_W-1:0] rdata1_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata0_o <= (we_i && (waddr_i == raddr0_i)) ? wdata_i : mem[raddr0_i];
    rdata1_o <= (we_i && (waddr_i == raddr1_i)) ? wdata_i : mem[raddr1_i];
  end

endmodule

// File: src/bll_ctrl.sv
// Sequencer of the lifting engine: walks the ancestor and depth memories
// for add and query items. Depends on bll_pkg.
module bll_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           opcode_i,
  input  logic [bll_pkg::NODE_W-1:0]     node_a_i,
  input  logic [bll_pkg::NODE_W-1:0]     node_b_i,
  output bll_pkg::bll_anc_req_t          anc_req_o,
  input  logic [bll_pkg::NODE_W-1:0]     anc_rdata0_i,
  input  logic [bll_pkg::NODE_W-1:0]     anc_rdata1_i,
  output bll_pkg::bll_dep_req_t          dep_req_o,
  input  logic [bll_pkg::DEPTH_W-1:0]    dep_rdata0_i,
  input  logic [bll_pkg::DEPTH_W-1:0]    dep_rdata1_i,
  output bll_pkg::bll_res_t              res_o,
  input  logic                           res_ready_i
);

  bll_pkg::bll_state_e state_q, state_d;

  logic [bll_pkg::LVL_W-1:0]   lvl_q, lvl_d;
  logic [bll_pkg::NODE_W-1:0]  u_q, u_d;
  logic [bll_pkg::NODE_W-1:0]  x_q, x_d;
  logic [bll_pkg::NODE_W-1:0]  y_q, y_d;
  logic [bll_pkg::NODE_W-1:0]  c_q, c_d;
  logic [bll_pkg::NODE_W-1:0]  res_q, res_d;
  logic [bll_pkg::DEPTH_W-1:0] dy_q, dy_d;

  logic                        in_xfer;
  logic                        is_add;
  logic                        same_ab;
  logic                        swap;
  logic [bll_pkg::NODE_W-1:0]  x_swap;
  logic [bll_pkg::NODE_W-1:0]  x_up;
  logic                        differ;
  logic [bll_pkg::NODE_W-1:0]  x_lift;
  logic [bll_pkg::NODE_W-1:0]  y_lift;
  logic [bll_pkg::LVL_W-1:0]   lvl_dn;

  assign in_xfer = in_valid_i && (state_q == bll_pkg::ST_IDLE);
  assign is_add  = (opcode_i == bll_pkg::OP_ADD);
  assign same_ab = (node_a_i == node_b_i);

  // The deeper of the two query nodes is the one lifted first.
  assign swap   = (dep_rdata0_i < dep_rdata1_i);
  assign x_swap = swap ? y_q : x_q;
  assign x_up   = (dep_rdata0_i >= dy_q) ? c_q : x_q;
  assign differ = (anc_rdata0_i != anc_rdata1_i);
  assign x_lift = differ ? anc_rdata0_i : x_q;
  assign y_lift = differ ? anc_rdata1_i : y_q;
  assign lvl_dn = (lvl_q == '0) ? lvl_q : lvl_q - 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bll_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (is_add) begin
            if (!same_ab) begin
              state_d = bll_pkg::ST_ADD_DEP;
            end else if (bll_pkg::LIFT_LEVELS > 1) begin
              state_d = bll_pkg::ST_ADD_LIFT;
            end
          end else begin
            state_d = same_ab ? bll_pkg::ST_DONE : bll_pkg::ST_Q_DEP;
          end
        end
      end
      bll_pkg::ST_ADD_DEP: begin
        state_d = (bll_pkg::LIFT_LEVELS > 1) ? bll_pkg::ST_ADD_LIFT : bll_pkg::ST_IDLE;
      end
      bll_pkg::ST_ADD_LIFT: begin
        if (lvl_q == bll_pkg::LVL_LAST) state_d = bll_pkg::ST_IDLE;
      end
      bll_pkg::ST_Q_DEP:    state_d = bll_pkg::ST_Q_UP_ANC;
      bll_pkg::ST_Q_UP_ANC: state_d = bll_pkg::ST_Q_UP_DEP;
      bll_pkg::ST_Q_UP_DEP: begin
        state_d = (lvl_q == '0) ? bll_pkg::ST_Q_CHK : bll_pkg::ST_Q_UP_ANC;
      end
      bll_pkg::ST_Q_CHK: begin
        state_d = (x_q == y_q) ? bll_pkg::ST_DONE : bll_pkg::ST_Q_LIFT;
      end
      bll_pkg::ST_Q_LIFT: begin
        if (lvl_q == '0) state_d = bll_pkg::ST_Q_FIN;
      end
      bll_pkg::ST_Q_FIN: state_d = bll_pkg::ST_DONE;
      bll_pkg::ST_DONE: begin
        if (res_ready_i) state_d = bll_pkg::ST_IDLE;
      end
      default: state_d = bll_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    lvl_d = lvl_q;
    u_d   = u_q;
    x_d   = x_q;
    y_d   = y_q;
    c_d   = c_q;
    dy_d  = dy_q;
    res_d = res_q;
    case (state_q)
      bll_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          u_d   = node_a_i;
          x_d   = node_a_i;
          y_d   = node_b_i;
          res_d = node_a_i;
          lvl_d = bll_pkg::LVL_FIRST;
        end
      end
      bll_pkg::ST_ADD_LIFT: lvl_d = lvl_q + 1'b1;
      bll_pkg::ST_Q_DEP: begin
        x_d   = x_swap;
        y_d   = swap ? x_q : y_q;
        dy_d  = swap ? dep_rdata0_i : dep_rdata1_i;
        lvl_d = bll_pkg::LVL_LAST;
      end
      bll_pkg::ST_Q_UP_ANC: c_d = anc_rdata0_i;
      bll_pkg::ST_Q_UP_DEP: begin
        x_d   = x_up;
        lvl_d = lvl_dn;
      end
      bll_pkg::ST_Q_CHK: begin
        res_d = x_q;
        lvl_d = bll_pkg::LVL_LAST;
      end
      bll_pkg::ST_Q_LIFT: begin
        x_d   = x_lift;
        y_d   = y_lift;
        lvl_d = lvl_dn;
      end
      bll_pkg::ST_Q_FIN: res_d = anc_rdata0_i;
      default: ;
    endcase
  end

  always_comb begin
    anc_req_o  = '0;
    dep_req_o  = '0;
    in_stall_o = (state_q != bll_pkg::ST_IDLE);
    res_o.valid = (state_q == bll_pkg::ST_DONE);
    res_o.node  = res_q;
    unique case (state_q)
      bll_pkg::ST_IDLE: begin
        if (in_xfer && is_add && same_ab) begin
          // A root is its own ancestor at every level.
          dep_req_o.we     = 1'b1;
          dep_req_o.waddr  = node_a_i;
          dep_req_o.wdata  = '0;
          anc_req_o.we     = 1'b1;
          anc_req_o.waddr  = bll_pkg::anc_addr(node_a_i, '0);
          anc_req_o.wdata  = node_a_i;
          anc_req_o.raddr0 = bll_pkg::anc_addr(node_a_i, '0);
        end else if (in_xfer && is_add) begin
          dep_req_o.raddr0 = node_b_i;
        end else if (in_xfer) begin
          dep_req_o.raddr0 = node_a_i;
          dep_req_o.raddr1 = node_b_i;
        end
      end
      bll_pkg::ST_ADD_DEP: begin
        dep_req_o.we     = 1'b1;
        dep_req_o.waddr  = u_q;
        dep_req_o.wdata  = bll_pkg::depth_inc(dep_rdata0_i);
        anc_req_o.we     = 1'b1;
        anc_req_o.waddr  = bll_pkg::anc_addr(u_q, '0);
        anc_req_o.wdata  = y_q;
        anc_req_o.raddr0 = bll_pkg::anc_addr(y_q, '0);
      end
      bll_pkg::ST_ADD_LIFT: begin
        // Level i is the level i-1 ancestor of the level i-1 ancestor.
        anc_req_o.we     = 1'b1;
        anc_req_o.waddr  = bll_pkg::anc_addr(u_q, lvl_q);
        anc_req_o.wdata  = anc_rdata0_i;
        anc_req_o.raddr0 = bll_pkg::anc_addr(anc_rdata0_i, lvl_q);
      end
      bll_pkg::ST_Q_DEP: begin
        anc_req_o.raddr0 = bll_pkg::anc_addr(x_swap, bll_pkg::LVL_LAST);
      end
      bll_pkg::ST_Q_UP_ANC: dep_req_o.raddr0 = anc_rdata0_i;
      bll_pkg::ST_Q_UP_DEP: anc_req_o.raddr0 = bll_pkg::anc_addr(x_up, lvl_dn);
      bll_pkg::ST_Q_CHK: begin
        anc_req_o.raddr0 = bll_pkg::anc_addr(x_q, bll_pkg::LVL_LAST);
        anc_req_o.raddr1 = bll_pkg::anc_addr(y_q, bll_pkg::LVL_LAST);
      end
      bll_pkg::ST_Q_LIFT: begin
        // At the lowest level the final read fetches the parent of x.
        anc_req_o.raddr0 = bll_pkg::anc_addr(x_lift, lvl_dn);
        anc_req_o.raddr1 = bll_pkg::anc_addr(y_lift, lvl_dn);
      end
      bll_pkg::ST_Q_FIN: ;
      bll_pkg::ST_DONE:  ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bll_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
    u_q   <= u_d;
    x_q   <= x_d;
    y_q   <= y_d;
    c_q   <= c_d;
    dy_q  <= dy_d;
    res_q <= res_d;
  end

endmodule

// File: tb/sv/binary_lifting_lca_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of binary_lifting_lca_top: grows random trees, asks
// common-ancestor queries and checks every answer against its own lifting tables.
// Depends on bll_pkg and binary_lifting_lca_top.
module binary_lifting_lca_top_tb;

  localparam int NODE_W        = bll_pkg::NODE_W;
  localparam int DEPTH_W       = bll_pkg::DEPTH_W;
  localparam int LIFT_LEVELS   = bll_pkg::LIFT_LEVELS;
  localparam int NODE_COUNT    = 1 << NODE_W;
  localparam int RANDOM_ITEMS  = 960;
  localparam int PUMP_ADDS     = 64;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 48;

  class lca_scoreboard;
    logic [NODE_W-1:0]  lift_tbl [NODE_COUNT][LIFT_LEVELS];
    logic [DEPTH_W-1:0] depth_tbl [NODE_COUNT];
    logic [NODE_W-1:0]  expected_ancestors [$];
    int failures = 0;
    int checked = 0;

    function void graft_node(logic [NODE_W-1:0] child, logic [NODE_W-1:0] parent);
      int d;
      if (child == parent) begin
        d = 0;
      end else begin
        d = int'(depth_tbl[parent]) + 1;
        if (d >= (1 << DEPTH_W)) d = (1 << DEPTH_W) - 1;
      end
      depth_tbl[child] = DEPTH_W'(d);
      lift_tbl[child][0] = parent;
      for (int i = 1; i < LIFT_LEVELS; i++) begin
        lift_tbl[child][i] = lift_tbl[lift_tbl[child][i-1]][i-1];
      end
    endfunction

    function logic [NODE_W-1:0] lowest_common(logic [NODE_W-1:0] x, logic [NODE_W-1:0] y);
      logic [NODE_W-1:0] t;
      if (x == y) return x;
      if (depth_tbl[x] < depth_tbl[y]) begin
        t = x;
        x = y;
        y = t;
      end
      // Bring the deeper node up to the depth of the other one.
      for (int i = LIFT_LEVELS - 1; i >= 0; i--) begin
        if (depth_tbl[lift_tbl[x][i]] >= depth_tbl[y]) x = lift_tbl[x][i];
      end
      if (x == y) return x;
      for (int i = LIFT_LEVELS - 1; i >= 0; i--) begin
        if (lift_tbl[x][i] != lift_tbl[y][i]) begin
          x = lift_tbl[x][i];
          y = lift_tbl[y][i];
        end
      end
      return lift_tbl[x][0];
    endfunction

    function void note_input(bll_pkg::bll_op_e op, logic [NODE_W-1:0] a,
                             logic [NODE_W-1:0] b);
      if (op == bll_pkg::OP_ADD) graft_node(a, b);
      else expected_ancestors.push_back(lowest_common(a, b));
    endfunction

    function void check_result(logic [NODE_W-1:0] got);
      logic [NODE_W-1:0] want;
      checked++;
      if (expected_ancestors.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected ancestor_node %0d with no query waiting", got);
        return;
      end
      want = expected_ancestors.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10) begin
          $display("ancestor_node mismatch: expected %0d, got %0d", want, got);
        end
      end
    endfunction

    function int pending();
      return expected_ancestors.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              opcode_i;
  logic [NODE_W-1:0] node_a_i;
  logic [NODE_W-1:0] node_b_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [NODE_W-1:0] ancestor_node_o;

  lca_scoreboard sb = new();

  // Nodes that have been added, so that queries and parents never hit an
  // entry that was never written.
  bit known [NODE_COUNT];
  int known_list [$];
  int recent [$];
  int sent = 0;

  binary_lifting_lca_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ancestor_node_o(ancestor_node_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_item(input bll_pkg::bll_op_e op, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b);
    int gap;
    // Every fifth stretch of 80 items goes back to back.
    gap = (((sent / 80) % 5) == 4) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    node_a_i   <= a;
    node_b_i   <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_input(op, a, b);
    sent++;
    if (op == bll_pkg::OP_ADD) begin
      if (!known[a]) begin
        known[a] = 1'b1;
        known_list.push_back(a);
      end
      recent.push_back(a);
      if (recent.size() > 8) void'(recent.pop_front());
    end
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [NODE_W-1:0] pick_known();
    return NODE_W'(known_list[$urandom_range(0, known_list.size() - 1)]);
  endfunction

  function automatic logic [NODE_W-1:0] pick_recent();
    return NODE_W'(recent[$urandom_range(0, recent.size() - 1)]);
  endfunction

  initial begin : stimulus
    logic [NODE_W-1:0] a, b, u, v;
    int roll;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    opcode_i   <= bll_pkg::OP_ADD;
    node_a_i   <= '0;
    node_b_i   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes, alternating bit patterns, equal nodes, a node that is the
    // ancestor of the other, a re-added node and a second separate tree.
    send_item(bll_pkg::OP_ADD, 10'd0, 10'd0);
    send_item(bll_pkg::OP_ADD, 10'd1023, 10'd0);
    send_item(bll_pkg::OP_ADD, 10'd512, 10'd1023);
    send_item(bll_pkg::OP_ADD, 10'd341, 10'd0);
    send_item(bll_pkg::OP_ADD, 10'd682, 10'd341);
    send_item(bll_pkg::OP_QUERY, 10'd512, 10'd682);
    send_item(bll_pkg::OP_QUERY, 10'd1023, 10'd1023);
    send_item(bll_pkg::OP_QUERY, 10'd0, 10'd0);
    send_item(bll_pkg::OP_QUERY, 10'd512, 10'd1023);
    send_item(bll_pkg::OP_QUERY, 10'd1023, 10'd512);
    send_item(bll_pkg::OP_QUERY, 10'd682, 10'd341);
    send_item(bll_pkg::OP_QUERY, 10'd0, 10'd1023);
    send_item(bll_pkg::OP_ADD, 10'd1023, 10'd341);
    send_item(bll_pkg::OP_QUERY, 10'd512, 10'd682);
    send_item(bll_pkg::OP_QUERY, 10'd1023, 10'd682);
    send_item(bll_pkg::OP_ADD, 10'd100, 10'd100);
    send_item(bll_pkg::OP_QUERY, 10'd100, 10'd512);
    send_item(bll_pkg::OP_ADD, 10'd101, 10'd100);
    send_item(bll_pkg::OP_QUERY, 10'd101, 10'd100);

    // Random growth: parents lean toward recent nodes so chains get deep.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) hold_until_drained();
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        a = $urandom_range(0, 1) ? pick_recent() : pick_known();
        if (roll < 5) b = a;
        else b = $urandom_range(0, 1) ? pick_recent() : pick_known();
        send_item(bll_pkg::OP_QUERY, a, b);
      end else begin
        a = NODE_W'($urandom_range(0, NODE_COUNT - 1));
        if (roll >= 96) b = a;
        else if ($urandom_range(0, 2) != 0) b = pick_recent();
        else b = pick_known();
        send_item(bll_pkg::OP_ADD, a, b);
      end
    end

    // Two nodes re-added as each other's parent gain one level per transfer,
    // so their ancestor levels point back into the pair.
    hold_until_drained();
    u = pick_known();
    do v = NODE_W'($urandom_range(0, NODE_COUNT - 1)); while (v == u);
    send_item(bll_pkg::OP_ADD, u, u);
    send_item(bll_pkg::OP_ADD, v, u);
    for (int k = 0; k < PUMP_ADDS; k++) begin
      if (k % 2 == 0) send_item(bll_pkg::OP_ADD, u, v);
      else send_item(bll_pkg::OP_ADD, v, u);
      if (k % 16 == 15) send_item(bll_pkg::OP_QUERY, u, pick_known());
    end
    send_item(bll_pkg::OP_QUERY, u, v);
    send_item(bll_pkg::OP_QUERY, v, u);
    send_item(bll_pkg::OP_QUERY, u, u);
    send_item(bll_pkg::OP_QUERY, pick_known(), v);

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : result_side
    int hold;
    bit held_long;
    held_long = 1'b0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      // One long hold-off lets the block fill up and stall its input.
      if (!held_long && sb.checked == 120) begin
        hold = LONG_HOLD;
        held_long = 1'b1;
      end else if (((sb.checked / 40) % 5) == 4) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 18);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_result(ancestor_node_o);
    end
  end

endmodule

// File: sim.f
src/bll_pkg.sv
src/bll_ram.sv
src/bll_ctrl.sv
src/binary_lifting_lca_top.sv
tb/sv/binary_lifting_lca_top_tb.sv
